### rtl/urrb_pkg.sv
`timescale 1ns / 1ps

package urrb_pkg;

    // Default ring depth; each ring holds at most one byte fewer than this.
    localparam int URRB_DEPTH = 64;

    // Fixed field widths.
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 6;
    localparam int COUNT_W = 16;

    // Operation codes carried in the op field.
    localparam logic [OP_W-1:0] OP_RX_BYTE = 3'd0;
    localparam logic [OP_W-1:0] OP_TX_EMPTY = 3'd1;
    localparam logic [OP_W-1:0] OP_HOST_WR = 3'd2;
    localparam logic [OP_W-1:0] OP_HOST_RD = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_TXEN = 3'd4;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_OUT  = 3'b100
    } urrb_state_t;

    // Source of the byte reported in the result.
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_DATA,
        SEL_RX,
        SEL_TX
    } urrb_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // input transfer: update rings and counters
        logic finish;  // capture the result from updated state
    } urrb_cmd_t;

    // One input item.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic              line_error;
    } urrb_item_t;

    // One result item.
    typedef struct packed {
        logic               out_valid;
        logic [BYTE_W-1:0]  out_byte;
        logic               accepted;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic [COUNT_W-1:0] overflow_total;
        logic [COUNT_W-1:0] error_total;
        logic               tx_enable_now;
    } urrb_result_t;

endpackage

### rtl/urrb_if.sv
`timescale 1ns / 1ps

// Input channel: one operation per transfer.
interface urrb_in_if import urrb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic              line_error;

    modport source (output valid, output op, output data, output line_error, input ready);
    modport sink (input valid, input op, input data, input line_error, output ready);
endinterface

// Result channel: one status result per transfer.
interface urrb_out_if import urrb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               out_valid;
    logic [BYTE_W-1:0]  out_byte;
    logic               accepted;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic [COUNT_W-1:0] overflow_total;
    logic [COUNT_W-1:0] error_total;
    logic               tx_enable_now;

    modport source (
        output valid, output out_valid, output out_byte, output accepted,
        output rx_level, output tx_level, output overflow_total,
        output error_total, output tx_enable_now, input ready
    );
    modport sink (
        input valid, input out_valid, input out_byte, input accepted,
        input rx_level, input tx_level, input overflow_total,
        input error_total, input tx_enable_now, output ready
    );
endinterface

### rtl/uart_rx_tx_ring_buffer_engine_top.sv
`timescale 1ns / 1ps

// Buffered UART front end with a receive ring and a transmit ring, each DEPTH
// entries deep and holding up to DEPTH-1 bytes. Every accepted operation gives
// exactly one status result. An item is taken, its result is captured in the
// execute state and then shown, and the next item is taken in the cycle after
// that result transfer; the ring memories are read into registers as the item
// is taken. The forwarding enable is written through cfg_we and cfg_wdata; the
// user is to write it only while idle, as the block itself does not enforce it.
module uart_rx_tx_ring_buffer_engine_top import urrb_pkg::*; #(
    parameter int DEPTH = URRB_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    urrb_in_if.sink   in_item,
    urrb_out_if.source result,
    input  logic cfg_we,
    input  logic cfg_wdata
);

    urrb_cmd_t    cmd;
    urrb_item_t   item;
    urrb_result_t res;

    // Input payload gathered into one item.
    assign item.op         = in_item.op;
    assign item.data       = in_item.data;
    assign item.line_error = in_item.line_error;

    urrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_ready  (in_item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    urrb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (res)
    );

    // Result payload onto the output channel.
    assign result.out_valid      = res.out_valid;
    assign result.out_byte       = res.out_byte;
    assign result.accepted       = res.accepted;
    assign result.rx_level       = res.rx_level;
    assign result.tx_level       = res.tx_level;
    assign result.overflow_total = res.overflow_total;
    assign result.error_total    = res.error_total;
    assign result.tx_enable_now  = res.tx_enable_now;

endmodule

### rtl/urrb_ctrl.sv
`timescale 1ns / 1ps

module urrb_ctrl import urrb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output urrb_cmd_t cmd
);

    urrb_state_t state_reg;
    urrb_state_t state_next;
    logic        in_fire;
    logic        out_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    // Datapath commands.
    assign cmd.load   = in_fire;
    assign cmd.finish = (state_reg == ST_EXEC);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted item produces its result once the execute state has passed.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ##2 out_valid)
        else $error("result did not follow an accepted item");

    // No new item is taken while one is in progress.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input taken while an item was in progress");

    // Once the result transfer completes the block is ready again.
    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> in_ready)
        else $error("block not ready after result transfer");

endmodule

### rtl/urrb_datapath.sv
`timescale 1ns / 1ps

module urrb_datapath import urrb_pkg::*; #(
    parameter int DEPTH = URRB_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  urrb_cmd_t    cmd,
    input  urrb_item_t   item,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    output urrb_result_t result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

    // Ring storage.
    logic [BYTE_W-1:0] rx_mem [DEPTH];
    logic [BYTE_W-1:0] tx_mem [DEPTH];
    logic [BYTE_W-1:0] rx_rd_reg;
    logic [BYTE_W-1:0] tx_rd_reg;

    // Ring pointers, counters and flags.
    logic [PTR_W-1:0]   rx_head_reg;
    logic [PTR_W-1:0]   rx_tail_reg;
    logic [PTR_W-1:0]   tx_head_reg;
    logic [PTR_W-1:0]   tx_tail_reg;
    logic [COUNT_W-1:0] ovf_cnt_reg;
    logic [COUNT_W-1:0] err_cnt_reg;
    logic               txen_reg;
    logic               fwd_en_reg;

    // Per-item latched decisions.
    urrb_sel_t         sel_reg;
    logic              acc_reg;
    logic [BYTE_W-1:0] data_reg;

    urrb_result_t res_reg;

    // Pointer increments and ring status.
    logic [PTR_W-1:0] rx_head_inc;
    logic [PTR_W-1:0] rx_tail_inc;
    logic [PTR_W-1:0] tx_head_inc;
    logic [PTR_W-1:0] tx_tail_inc;
    logic             rx_full;
    logic             rx_empty;
    logic             tx_full;
    logic             tx_empty;

    assign rx_head_inc = (rx_head_reg == PTR_LAST) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == PTR_LAST) ? '0 : rx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == PTR_LAST) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == PTR_LAST) ? '0 : tx_tail_reg + 1'b1;
    assign rx_full     = (rx_head_inc == rx_tail_reg);
    assign rx_empty    = (rx_head_reg == rx_tail_reg);
    assign tx_full     = (tx_head_inc == tx_tail_reg);
    assign tx_empty    = (tx_head_reg == tx_tail_reg);

    // Fill levels from the current pointers, cut to the reported width.
    logic [PTR_W-1:0]         rx_lvl;
    logic [PTR_W-1:0]         tx_lvl;
    logic [PTR_W+LEVEL_W-1:0] rx_lvl_ext;
    logic [PTR_W+LEVEL_W-1:0] tx_lvl_ext;

    always_comb
    begin
        if (rx_head_reg >= rx_tail_reg)
        begin
            rx_lvl = rx_head_reg - rx_tail_reg;
        end
        else
        begin
            rx_lvl = PTR_W'({1'b0, rx_head_reg} + DEPTH_EXT - {1'b0, rx_tail_reg});
        end
        if (tx_head_reg >= tx_tail_reg)
        begin
            tx_lvl = tx_head_reg - tx_tail_reg;
        end
        else
        begin
            tx_lvl = PTR_W'({1'b0, tx_head_reg} + DEPTH_EXT - {1'b0, tx_tail_reg});
        end
    end

    assign rx_lvl_ext = {{LEVEL_W{1'b0}}, rx_lvl};
    assign tx_lvl_ext = {{LEVEL_W{1'b0}}, tx_lvl};

    // Forwarding enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            fwd_en_reg <= cfg_wdata;
        end
    end

    // Ring memories: write on store, registered read at the tail.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (item.op == OP_RX_BYTE && !rx_full)
            begin
                rx_mem[rx_head_reg] <= item.data;
            end
            if (item.op == OP_HOST_WR && !tx_full)
            begin
                tx_mem[tx_head_reg] <= item.data;
            end
            rx_rd_reg <= rx_mem[rx_tail_reg];
            tx_rd_reg <= tx_mem[tx_tail_reg];
        end
    end

    // Ring pointers, counters and transmit enable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            ovf_cnt_reg <= '0;
            err_cnt_reg <= '0;
            txen_reg    <= 1'b0;
            sel_reg     <= SEL_NONE;
            acc_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            sel_reg <= SEL_NONE;
            acc_reg <= 1'b0;
            unique case (item.op)
                OP_RX_BYTE:
                begin
                    if (item.line_error && err_cnt_reg != '1)
                    begin
                        err_cnt_reg <= err_cnt_reg + 1'b1;
                    end
                    if (!rx_full)
                    begin
                        rx_head_reg <= rx_head_inc;
                        acc_reg     <= 1'b1;
                    end
                    else if (ovf_cnt_reg != '1)
                    begin
                        ovf_cnt_reg <= ovf_cnt_reg + 1'b1;
                    end
                    if (fwd_en_reg)
                    begin
                        sel_reg <= SEL_DATA;
                    end
                end
                OP_TX_EMPTY:
                begin
                    if (txen_reg)
                    begin
                        if (!tx_empty)
                        begin
                            sel_reg     <= SEL_TX;
                            tx_tail_reg <= tx_tail_inc;
                        end
                        else
                        begin
                            txen_reg <= 1'b0;
                        end
                    end
                end
                OP_HOST_WR:
                begin
                    if (!tx_full)
                    begin
                        tx_head_reg <= tx_head_inc;
                        acc_reg     <= 1'b1;
                        txen_reg    <= 1'b1;
                    end
                end
                OP_HOST_RD:
                begin
                    if (!rx_empty)
                    begin
                        sel_reg     <= SEL_RX;
                        rx_tail_reg <= rx_tail_inc;
                    end
                end
                OP_SET_TXEN:
                begin
                    txen_reg <= item.data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Incoming byte kept for forwarding.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            data_reg <= item.data;
        end
    end

    // Result capture from the updated state.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_reg.out_valid      <= (sel_reg != SEL_NONE);
            res_reg.accepted       <= acc_reg;
            res_reg.rx_level       <= rx_lvl_ext[LEVEL_W-1:0];
            res_reg.tx_level       <= tx_lvl_ext[LEVEL_W-1:0];
            res_reg.overflow_total <= ovf_cnt_reg;
            res_reg.error_total    <= err_cnt_reg;
            res_reg.tx_enable_now  <= txen_reg;
            case (sel_reg)
                SEL_DATA: res_reg.out_byte <= data_reg;
                SEL_RX:   res_reg.out_byte <= rx_rd_reg;
                SEL_TX:   res_reg.out_byte <= tx_rd_reg;
                default:  res_reg.out_byte <= '0;
            endcase
        end
    end

    assign result = res_reg;

    // Pointers always stay inside the ring.
    a_rx_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_head_reg <= PTR_LAST) && (rx_tail_reg <= PTR_LAST))
        else $error("receive pointer outside the ring");

    a_tx_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_head_reg <= PTR_LAST) && (tx_tail_reg <= PTR_LAST))
        else $error("transmit pointer outside the ring");

endmodule
